@@ hdl/filtered_pi_speed_loop_core_assert.svh @@
// Assertion macros for the filtered PI speed loop core.
// Expects signals named clk and rst in the including module.
`ifndef FILTERED_PI_SPEED_LOOP_CORE_ASSERT_SVH
`define FILTERED_PI_SPEED_LOOP_CORE_ASSERT_SVH

`ifndef SYNTHESIS
`define FPSL_ASSERT_IMPLY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fpsl assertion failed");
`define FPSL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fpsl assertion failed");
`else
`define FPSL_ASSERT_IMPLY(lbl, ante, cons)
`define FPSL_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

@@ hdl/fpsl_pkg.sv @@
// Shared types, constants and the divide-by-five helper of the speed loop.
// No dependencies.
package fpsl_pkg;

  localparam int CfgIndexW = 8;

  typedef enum logic [CfgIndexW-1:0] {
    REG_GAIN_P     = 8'd0,
    REG_GAIN_I     = 8'd1,
    REG_INT_LIMIT  = 8'd2,
    REG_TILT_LIMIT = 8'd3
  } cfg_reg_t;

  localparam logic [15:0] INT_LIMIT_RESET  = 16'd8000;
  localparam logic [7:0]  TILT_LIMIT_RESET = 8'd60;

  // floor(2^22 / 5); the quotient comes out at most one low, fixed up below
  localparam logic [19:0] DIV5_RECIP = 20'd838860;
  localparam int          DIV5_SHIFT = 22;

  typedef struct packed {
    logic signed [20:0] quo;
    logic signed [3:0]  rem;
  } div5_t;

  // Signed divide by five, quotient truncated toward zero, remainder takes
  // the sign of the dividend. Dividend magnitude must stay within 2^20.
  function automatic div5_t div5(input logic signed [20:0] x);
    logic [20:0] mag;
    logic [40:0] prod;
    logic [20:0] q;
    logic [20:0] r;
    div5_t       res;
    mag  = x[20] ? 21'(-x) : 21'(x);
    prod = 41'(mag) * 41'(DIV5_RECIP);
    q    = 21'(prod >> DIV5_SHIFT);
    r    = mag - 21'(q * 21'd5);
    if (r >= 21'd5) begin
      q = q + 21'd1;
      r = r - 21'd5;
    end
    res.quo = x[20] ? -signed'(q) : signed'(q);
    res.rem = x[20] ? -signed'(4'(r)) : signed'(4'(r));
    return res;
  endfunction

endpackage

@@ hdl/filtered_pi_speed_loop_core.sv @@
// Filtered PI speed loop core; uses fpsl_pkg and filtered_pi_speed_loop_core_assert.svh.
// Throughput: one word per cycle while m_tready allows; the filter and integral
// loops each close in a single stage. Stages: input, error/5, filter update,
// integral update, gain products, scale and saturate. Synchronous active-high
// reset clears valids, both accumulators and the registers to their defaults.
`include "filtered_pi_speed_loop_core_assert.svh"

module filtered_pi_speed_loop_core (
  input  logic        clk,
  input  logic        rst,
  // slave side
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // left_speed[15:0], right_speed[31:16],
                                 // target_speed[47:32], tilt_angle[56:48], pad
  // master side
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // speed_drive[15:0]
  output logic        m_tuser,   // tilt_fault[0]
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [fpsl_pkg::CfgIndexW-1:0] cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  logic signed [15:0] speed_gain_p;
  logic signed [15:0] speed_gain_i;
  logic [15:0]        integral_limit;
  logic [7:0]         tilt_limit;

  // loop state
  logic signed [17:0] filtered_error;
  logic signed [16:0] error_integral;

  // stage registers
  logic               a_valid;
  logic signed [15:0] a_left, a_right, a_target;
  logic signed [8:0]  a_tilt;

  logic               b_valid;
  logic signed [17:0] b_quo;
  logic signed [3:0]  b_rem;
  logic               b_fault;

  logic               c_valid;
  logic signed [17:0] c_filt;
  logic               c_fault;

  logic               d_valid;
  logic signed [17:0] d_filt;
  logic signed [16:0] d_integ;
  logic               d_fault;

  logic               e_valid;
  logic signed [33:0] e_prod_p;
  logic signed [32:0] e_prod_i;
  logic               e_fault;

  // per-stage ready, bubbles collapse
  logic rdy_out, rdy_e, rdy_d, rdy_c, rdy_b;

  assign rdy_out  = !m_tvalid || m_tready;
  assign rdy_e    = !e_valid || rdy_out;
  assign rdy_d    = !d_valid || rdy_e;
  assign rdy_c    = !c_valid || rdy_d;
  assign rdy_b    = !b_valid || rdy_c;
  assign s_tready = !a_valid || rdy_b;
  assign cfg_ready = 1'b1;

  // stage B: error and its fifth, tilt compare
  logic signed [17:0] err_sum;
  fpsl_pkg::div5_t    err_div;
  logic [8:0]         tilt_mag;

  assign err_sum  = 18'(a_left) + 18'(a_right) - 18'(a_target);
  assign err_div  = fpsl_pkg::div5(21'(err_sum));
  assign tilt_mag = a_tilt[8] ? 9'(-a_tilt) : 9'(a_tilt);

  // stage C: A = trunc(4F/5), F = trunc((5A + err)/5) via err = 5q + r
  fpsl_pkg::div5_t    filt_div;
  logic signed [18:0] filt_sum;
  logic signed [18:0] filt_adj;
  logic signed [17:0] filtered_error_next;

  assign filt_div = fpsl_pkg::div5(21'(signed'({filtered_error, 2'b00})));
  assign filt_sum = 19'(filt_div.quo) + 19'(b_quo);

  always_comb begin
    filt_adj = filt_sum;
    if (b_rem < 0 && filt_sum > 0) begin
      filt_adj = filt_sum - 19'sd1;
    end else if (b_rem > 0 && filt_sum < 0) begin
      filt_adj = filt_sum + 19'sd1;
    end
  end

  assign filtered_error_next = 18'(filt_adj);

  // stage D: integral with symmetric clamp
  logic signed [18:0] integ_sum;
  logic signed [18:0] integ_lim;
  logic signed [16:0] integ_clamped;

  assign integ_sum = 19'(error_integral) + 19'(c_filt);
  assign integ_lim = signed'({3'b000, integral_limit});

  always_comb begin
    if (integ_sum > integ_lim) begin
      integ_clamped = 17'(integ_lim);
    end else if (integ_sum < -integ_lim) begin
      integ_clamped = 17'(-integ_lim);
    end else begin
      integ_clamped = 17'(integ_sum);
    end
  end

  // output stage: divide by 256 toward zero, saturate
  logic signed [34:0] drive_sum;
  logic signed [34:0] drive_biased;
  logic signed [34:0] drive_scaled;
  logic signed [15:0] drive_sat;

  assign drive_sum    = 35'(e_prod_p) + 35'(e_prod_i);
  assign drive_biased = drive_sum + (drive_sum < 0 ? 35'sd255 : 35'sd0);
  assign drive_scaled = drive_biased >>> 8;

  always_comb begin
    if (drive_scaled > 35'sd32767) begin
      drive_sat = 16'sh7fff;
    end else if (drive_scaled < -35'sd32768) begin
      drive_sat = 16'sh8000;
    end else begin
      drive_sat = 16'(drive_scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_gain_p   <= '0;
      speed_gain_i   <= '0;
      integral_limit <= fpsl_pkg::INT_LIMIT_RESET;
      tilt_limit     <= fpsl_pkg::TILT_LIMIT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        fpsl_pkg::REG_GAIN_P:     speed_gain_p   <= signed'(cfg_data);
        fpsl_pkg::REG_GAIN_I:     speed_gain_i   <= signed'(cfg_data);
        fpsl_pkg::REG_INT_LIMIT:  integral_limit <= cfg_data;
        fpsl_pkg::REG_TILT_LIMIT: tilt_limit     <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      b_valid        <= 1'b0;
      c_valid        <= 1'b0;
      d_valid        <= 1'b0;
      e_valid        <= 1'b0;
      m_tvalid       <= 1'b0;
      filtered_error <= '0;
      error_integral <= '0;
    end else begin
      if (s_tready) begin
        a_valid <= s_tvalid;
      end
      if (rdy_b) begin
        b_valid <= a_valid;
      end
      if (rdy_c) begin
        c_valid <= b_valid;
        if (b_valid) begin
          filtered_error <= filtered_error_next;
        end
      end
      if (rdy_d) begin
        d_valid <= c_valid;
        if (c_valid) begin
          error_integral <= c_fault ? '0 : integ_clamped;
        end
      end
      if (rdy_e) begin
        e_valid <= d_valid;
      end
      if (rdy_out) begin
        m_tvalid <= e_valid;
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      a_left   <= signed'(s_tdata[15:0]);
      a_right  <= signed'(s_tdata[31:16]);
      a_target <= signed'(s_tdata[47:32]);
      a_tilt   <= signed'(s_tdata[56:48]);
    end
    if (rdy_b && a_valid) begin
      b_quo   <= 18'(err_div.quo);
      b_rem   <= err_div.rem;
      b_fault <= tilt_mag >= {1'b0, tilt_limit};
    end
    if (rdy_c && b_valid) begin
      c_filt  <= filtered_error_next;
      c_fault <= b_fault;
    end
    if (rdy_d && c_valid) begin
      d_filt  <= c_filt;
      d_integ <= integ_clamped;
      d_fault <= c_fault;
    end
    if (rdy_e && d_valid) begin
      e_prod_p <= 34'(speed_gain_p) * 34'(d_filt);
      e_prod_i <= 33'(speed_gain_i) * 33'(d_integ);
      e_fault  <= d_fault;
    end
    if (rdy_out && e_valid) begin
      m_tdata <= drive_sat;
      m_tuser <= e_fault;
    end
  end

  `FPSL_ASSERT_IMPLY(a_empty_out_takes_input, !m_tvalid, s_tready)
  `FPSL_ASSERT_NEXT(a_filter_moves_with_word, !(rdy_c && b_valid), $stable(filtered_error))
  `FPSL_ASSERT_NEXT(a_fault_clears_integral, rdy_d && c_valid && c_fault, error_integral == 0)
  `FPSL_ASSERT_NEXT(a_integral_holds_idle, !(rdy_d && c_valid), $stable(error_integral))

endmodule

@@ test/tb_filtered_pi_speed_loop_core.sv @@
// Self-checking bench for filtered_pi_speed_loop_core: drives control ticks and
// register writes, predicts drive and tilt fault per tick, checks every word.
// Depends on fpsl_pkg and the core RTL.
module tb_filtered_pi_speed_loop_core;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [fpsl_pkg::CfgIndexW-1:0] REG_UNMAPPED = 8'hFC;

  class drive_scoreboard;
    typedef struct {
      logic signed [15:0] drive;
      logic               fault;
    } tick_result_t;

    tick_result_t results_due[$];
    logic signed [15:0] gain_p;
    logic signed [15:0] gain_i;
    logic [15:0]        int_limit;
    logic [7:0]         tilt_limit;
    longint             filt_err;
    longint             err_sum;
    int                 errors;

    function new();
      gain_p     = '0;
      gain_i     = '0;
      int_limit  = fpsl_pkg::INT_LIMIT_RESET;
      tilt_limit = fpsl_pkg::TILT_LIMIT_RESET;
      filt_err   = 0;
      err_sum    = 0;
      errors     = 0;
    endfunction

    function void write_reg(input logic [fpsl_pkg::CfgIndexW-1:0] idx,
                            input logic [15:0] val);
      case (idx)
        fpsl_pkg::REG_GAIN_P:     gain_p = val;
        fpsl_pkg::REG_GAIN_I:     gain_i = val;
        fpsl_pkg::REG_INT_LIMIT:  int_limit = val;
        fpsl_pkg::REG_TILT_LIMIT: tilt_limit = val[7:0];
        default: ;
      endcase
    endfunction

    // One control tick: low-pass the error, integrate with clamp, apply gains, flag tilt fault.
    function void note_tick(input logic signed [15:0] left, input logic signed [15:0] right,
                            input logic signed [15:0] target, input logic signed [8:0] tilt);
      longint       err;
      longint       scaled;
      longint       integ;
      longint       drv;
      longint       mag;
      tick_result_t res;
      err      = longint'(left) + longint'(right) - longint'(target);
      scaled   = (4 * filt_err) / 5;
      filt_err = (5 * scaled + err) / 5;
      integ    = err_sum + filt_err;
      if (integ > longint'(int_limit)) integ = longint'(int_limit);
      if (integ < -longint'(int_limit)) integ = -longint'(int_limit);
      err_sum = integ;
      drv = (longint'(gain_p) * filt_err + longint'(gain_i) * integ) / 256;
      if (drv > 32767) drv = 32767;
      if (drv < -32768) drv = -32768;
      mag = (tilt < 0) ? -longint'(tilt) : longint'(tilt);
      res.fault = (mag >= longint'(tilt_limit));
      // integral clears only after the drive used it
      if (res.fault) err_sum = 0;
      res.drive = drv[15:0];
      results_due.push_back(res);
    endfunction

    task report_mismatch(input string field, input longint got, input longint want);
      $display("mismatch on %s: got %0d, expected %0d", field, got, want);
      errors++;
    endtask

    task check_result(input logic [15:0] drv, input logic flt);
      tick_result_t want;
      if (results_due.size() == 0) begin
        report_mismatch("word with none pending", longint'(signed'(drv)), 0);
        return;
      end
      want = results_due.pop_front();
      if (drv !== want.drive)
        report_mismatch("speed_drive", longint'(signed'(drv)), longint'(want.drive));
      if (flt !== want.fault)
        report_mismatch("tilt_fault", longint'(flt), longint'(want.fault));
    endtask
  endclass

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [63:0]                    s_tdata = '0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [15:0]                    m_tdata;
  logic                           m_tuser;
  logic                           cfg_valid = 1'b0;
  logic                           cfg_ready;
  logic [fpsl_pkg::CfgIndexW-1:0] cfg_index = '0;
  logic [15:0]                    cfg_data = '0;

  drive_scoreboard sb = new();
  int tx_idle_pct = 32;
  int rx_idle_pct = 85;
  int hold_req = 0;
  int hold_done = 0;
  int hold_left = 0;
  int cycles = 0;

  filtered_pi_speed_loop_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),   // left_speed, right_speed, target_speed, tilt_angle, pad
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),   // speed_drive
    .m_tuser   (m_tuser),   // tilt_fault
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver: random stalls plus an occasional long hold-off
  always @(negedge clk) begin
    if (hold_left == 0 && hold_req != hold_done) begin
      hold_done++;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
  end

  // called at a falling edge; leaves the valid high for the next word
  task send_tick(input logic signed [15:0] left, input logic signed [15:0] right,
                 input logic signed [15:0] target, input logic signed [8:0] tilt);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata  <= {$urandom, $urandom};
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {7'd0, tilt, target, right, left};
    do @(posedge clk); while (!s_tready);
    sb.note_tick(left, right, target, tilt);
    @(negedge clk);
  endtask

  task send_random();
    int   pick;
    logic signed [15:0] left;
    logic signed [15:0] right;
    logic signed [15:0] target;
    logic signed [8:0]  tilt;
    pick = $urandom_range(99);
    if (pick < 60) begin
      // plausible driving: speeds near target, moderate tilt
      left   = 16'($urandom_range(400) - 200);
      right  = 16'($urandom_range(400) - 200);
      target = 16'($urandom_range(800) - 400);
      tilt   = 9'($urandom_range(140) - 70);
    end else if (pick < 85) begin
      left   = 16'($urandom);
      right  = 16'($urandom);
      target = 16'($urandom);
      tilt   = 9'($urandom);
    end else begin
      left   = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      right  = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      target = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      case ($urandom_range(4))
        0: tilt = -9'sd256;
        1: tilt = -9'sd180;
        2: tilt = 9'sd0;
        3: tilt = 9'sd180;
        default: tilt = 9'sd255;
      endcase
    end
    send_tick(left, right, target, tilt);
  endtask

  task write_cfg(input logic [fpsl_pkg::CfgIndexW-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // sender stays quiet until every tick has produced its word
  task drain();
    s_tvalid <= 1'b0;
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    write_cfg(fpsl_pkg::REG_GAIN_P, 16'd384);
    write_cfg(fpsl_pkg::REG_GAIN_I, 16'd32);
    write_cfg(fpsl_pkg::REG_INT_LIMIT, 16'd1000);
    write_cfg(fpsl_pkg::REG_TILT_LIMIT, 16'd60);

    send_tick(16'sd0, 16'sd0, 16'sd0, 9'sd0);
    // largest positive error: drive saturates high, integral hits +limit
    repeat (4) send_tick(16'sh7FFF, 16'sh7FFF, 16'sh8000, 9'sd59);
    // largest negative error: integral swings down to -limit
    repeat (5) send_tick(16'sh8000, 16'sh8000, 16'sh7FFF, -9'sd59);
    send_tick(16'sd10, 16'sd20, 16'sd5, 9'sd60);
    send_tick(16'sd10, 16'sd20, 16'sd5, -9'sd60);
    send_tick(-16'sd7, 16'sd3, 16'sd1, 9'sd180);
    send_tick(-16'sd7, 16'sd3, 16'sd1, -9'sd180);
    send_tick(16'sd40, -16'sd2, 16'sd0, 9'sd255);
    send_tick(16'sd40, -16'sd2, 16'sd0, -9'sd256);
    // small errors exercise truncation toward zero
    send_tick(-16'sd3, 16'sd0, 16'sd0, 9'sd1);
    send_tick(16'sd2, 16'sd0, 16'sd0, -9'sd1);
    send_tick(16'sd0, -16'sd1, 16'sd3, 9'sd0);
    drain();

    // zero tilt limit faults every tick; unmapped index must be dropped
    write_cfg(fpsl_pkg::REG_TILT_LIMIT, 16'd0);
    write_cfg(fpsl_pkg::REG_INT_LIMIT, 16'd0);
    write_cfg(fpsl_pkg::REG_GAIN_P, 16'h8000);
    write_cfg(fpsl_pkg::REG_GAIN_I, 16'h7FFF);
    write_cfg(REG_UNMAPPED, 16'hFFFF);
    send_tick(16'sd100, 16'sd50, -16'sd30, 9'sd0);
    send_tick(16'sh7FFF, 16'sd1, 16'sd0, 9'sd5);
    send_tick(-16'sd9, -16'sd4, 16'sd100, -9'sd3);
    drain();

    write_cfg(fpsl_pkg::REG_GAIN_P, 16'h7FFF);
    write_cfg(fpsl_pkg::REG_GAIN_I, 16'h8000);
    write_cfg(fpsl_pkg::REG_INT_LIMIT, 16'hFFFF);
    write_cfg(fpsl_pkg::REG_TILT_LIMIT, 16'd180);
    repeat (130) send_random();
    drain();

    tx_idle_pct = 85;
    rx_idle_pct = 32;
    write_cfg(fpsl_pkg::REG_GAIN_P, -16'sd300);
    write_cfg(fpsl_pkg::REG_GAIN_I, -16'sd20);
    write_cfg(fpsl_pkg::REG_INT_LIMIT, 16'd0);
    write_cfg(fpsl_pkg::REG_TILT_LIMIT, 16'd255);
    repeat (130) send_random();
    drain();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    write_cfg(fpsl_pkg::REG_GAIN_P, 16'd200);
    write_cfg(fpsl_pkg::REG_GAIN_I, 16'd12);
    write_cfg(fpsl_pkg::REG_INT_LIMIT, 16'd2500);
    // upper byte is not part of the tilt limit
    write_cfg(fpsl_pkg::REG_TILT_LIMIT, 16'hFF2D);
    repeat (40) send_random();
    hold_req++;
    repeat (100) send_random();
    drain();
    repeat (20) @(negedge clk);

    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
